/* sv/assert_macros.svh */
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* sv/c8x_pkg.sv */
//------------------------------------------------------------------------------
// c8x_pkg
// Types and constants of the CHIP-8 instruction execute unit.
//------------------------------------------------------------------------------
`default_nettype none
package c8x_pkg;
  typedef enum logic [4:0] {
    K_RET = 5'd0, K_EXIT = 5'd1, K_JP = 5'd2, K_CALL = 5'd3, K_SEB = 5'd4,
    K_SNEB = 5'd5, K_SER = 5'd6, K_LDB = 5'd7, K_ADDB = 5'd8, K_LDR = 5'd9,
    K_OR = 5'd10, K_AND = 5'd11, K_XOR = 5'd12, K_ADDC = 5'd13, K_SUB = 5'd14,
    K_SHR = 5'd15, K_SUBN = 5'd16, K_SHL = 5'd17, K_SNER = 5'd18, K_LDI = 5'd19,
    K_JPO = 5'd20, K_LDVD = 5'd21, K_LDD = 5'd22, K_LDS = 5'd23, K_ADDI = 5'd24,
    K_FONT = 5'd25, K_BCD = 5'd26, K_STORE = 5'd27
  } kind_t;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_OVER = 2'd1;
  localparam logic [1:0] ERR_UNDER = 2'd2;

  localparam logic [15:0] PC_RESET = 16'h0200;

  localparam logic [1:0] CFG_LOGIC = 2'd0;
  localparam logic [1:0] CFG_SHIFT = 2'd1;
  localparam logic [1:0] CFG_JUMP = 2'd2;
  localparam logic [1:0] CFG_STORE = 2'd3;

  typedef struct packed {
    logic [4:0]  kind;
    logic [3:0]  x;
    logic [3:0]  y;
    logic [11:0] imm;
  } item_t;

  typedef struct packed {
    logic [15:0] pc;
    logic [15:0] index;
    logic        reg_written;
    logic [3:0]  reg_number;
    logic [7:0]  reg_value;
    logic [7:0]  flag_value;
    logic        mem_write;
    logic [15:0] mem_addr;
    logic [7:0]  mem_data;
    logic        last;
    logic [1:0]  error;
    logic        running;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic       exec;     // execute single-result part (item is latched by load)
    logic       mem_step; // emit memory word k
    logic [3:0] k;
    logic       k_last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       multi;   // item yields memory words (only while running)
    logic [3:0] count_m1;
  } stat_t;
endpackage
`default_nettype wire

/* sv/c8x_if.sv */
//------------------------------------------------------------------------------
// c8x_item_if / c8x_result_if
// Valid/ready channels for items and results.
//------------------------------------------------------------------------------
`default_nettype none
interface c8x_item_if import c8x_pkg::*; ;
  logic        valid;
  logic        ready;
  logic [4:0]  kind;
  logic [3:0]  x;
  logic [3:0]  y;
  logic [11:0] imm;
  modport source (output valid, kind, x, y, imm, input ready);
  modport sink (input valid, kind, x, y, imm, output ready);
endinterface

interface c8x_result_if import c8x_pkg::*; ;
  logic        valid;
  logic        ready;
  logic [15:0] pc;
  logic [15:0] index;
  logic        reg_written;
  logic [3:0]  reg_number;
  logic [7:0]  reg_value;
  logic [7:0]  flag_value;
  logic        mem_write;
  logic [15:0] mem_addr;
  logic [7:0]  mem_data;
  logic        last;
  logic [1:0]  error;
  logic        running;
  modport source (output valid, pc, index, reg_written, reg_number, reg_value,
    flag_value, mem_write, mem_addr, mem_data, last, error, running, input ready);
  modport sink (input valid, pc, index, reg_written, reg_number, reg_value,
    flag_value, mem_write, mem_addr, mem_data, last, error, running, output ready);
endinterface
`default_nettype wire

/* sv/c8x_ctrl.sv */
//------------------------------------------------------------------------------
// c8x_ctrl
// Sequencer: accepts an item, runs it, steps memory words, hands off words.
//------------------------------------------------------------------------------
`default_nettype none
module c8x_ctrl import c8x_pkg::*; (
  input  wire   clk,
  input  wire   rst_n,
  input  wire   in_valid,
  output logic  in_ready,
  input  wire   res_ready,   // output register free or draining
  output logic  res_load,    // datapath result goes to output register
  output cmd_t  cmd,
  input  stat_t stat
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001, S_EXEC = 3'b010, S_MEM = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic [3:0] k_r, k_nxt;

  always_comb begin
    state_nxt = state_r;
    k_nxt = k_r;
    in_ready = 1'b0;
    res_load = 1'b0;
    cmd = '0;
    cmd.k = k_r;
    cmd.k_last = (k_r == stat.count_m1);
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.multi) begin
          k_nxt = '0;
          state_nxt = S_MEM;
        end else if (res_ready) begin
          cmd.exec = 1'b1;
          res_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_MEM: begin
        if (res_ready) begin
          cmd.mem_step = 1'b1;
          res_load = 1'b1;
          k_nxt = k_r + 4'd1;
          if (cmd.k_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r <= '0;
    end else begin
      state_r <= state_nxt;
      k_r <= k_nxt;
    end
  end
endmodule
`default_nettype wire

/* sv/c8x_dp.sv */
//------------------------------------------------------------------------------
// c8x_dp
// Architectural state, ALU, return stack and result formation.
//------------------------------------------------------------------------------
`default_nettype none
module c8x_dp import c8x_pkg::*; #(
  parameter int STACK_DEPTH = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         load,        // capture accepted item
  input  item_t       item,
  input  cmd_t        cmd,
  output stat_t       stat,
  output result_t     res,
  input  wire  [3:0]  cfg_bits     // logic, shift, jump, store
);
  localparam int SW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);

  logic [7:0]  v_r [16];
  logic [15:0] pc_r, idx_r;
  logic [DW-1:0] sp_r;
  logic [7:0]  dly_r, snd_r;
  logic        run_r;
  item_t       it_r;
  logic [15:0] stk [STACK_DEPTH];
  logic [15:0] stk_q;
  // Vx, index and run state, latched per item
  logic [7:0]  vx_r;
  logic [15:0] base_r;
  logic        run_at_r;

  logic [7:0] vx, vy, src, jsrc, rv, fv, hund, tens, ones, q10, rem;
  logic       rw, fw;
  logic [1:0] err;
  logic [15:0] pc2, pc_new, idx_new;
  logic [8:0]  sum9;

  assign vx = v_r[it_r.x];
  assign vy = v_r[it_r.y];

  // Divide by ten by reciprocal multiply (exact for 0..255).
  always_comb begin
    logic [15:0] p;
    p = 16'(vx_r) * 16'd205;
    hund = (vx_r >= 8'd200) ? 8'd2 : (vx_r >= 8'd100) ? 8'd1 : 8'd0;
    q10 = {3'd0, p[15:11]};
    ones = vx_r - 8'(q10 * 8'd10);
    tens = (q10 >= 8'd20) ? q10 - 8'd20 : (q10 >= 8'd10) ? q10 - 8'd10 : q10;
    rem = ones;
  end

  assign stat.multi = run_at_r &&
    (it_r.kind == K_BCD || it_r.kind == K_STORE);
  assign stat.count_m1 = (it_r.kind == K_BCD) ? 4'd2 : it_r.x;

  always_comb begin
    pc2 = pc_r + 16'd2;
    pc_new = pc2;
    idx_new = idx_r;
    rw = 1'b0; fw = 1'b0; rv = '0; fv = '0; err = ERR_NONE;
    src = cfg_bits[CFG_SHIFT] ? vy : vx;
    jsrc = cfg_bits[CFG_JUMP] ? v_r[it_r.imm[11:8]] : v_r[0];
    sum9 = {1'b0, vx} + {1'b0, vy};
    case (it_r.kind)
      K_RET: begin
        if (sp_r == '0) err = ERR_UNDER;
        else pc_new = stk_q;
      end
      K_JP: pc_new = {4'd0, it_r.imm};
      K_CALL: begin
        if (sp_r == DW'(STACK_DEPTH)) err = ERR_OVER;
        else pc_new = {4'd0, it_r.imm};
      end
      K_SEB: if (vx == it_r.imm[7:0]) pc_new = pc2 + 16'd2;
      K_SNEB: if (vx != it_r.imm[7:0]) pc_new = pc2 + 16'd2;
      K_SER: if (vx == vy) pc_new = pc2 + 16'd2;
      K_SNER: if (vx != vy) pc_new = pc2 + 16'd2;
      K_LDB: begin rw = 1'b1; rv = it_r.imm[7:0]; end
      K_ADDB: begin rw = 1'b1; rv = vx + it_r.imm[7:0]; end
      K_LDR: begin rw = 1'b1; rv = vy; end
      K_OR, K_AND, K_XOR: begin
        rw = 1'b1;
        rv = (it_r.kind == K_OR) ? (vx | vy) : (it_r.kind == K_AND) ? (vx & vy)
           : (vx ^ vy);
        fw = cfg_bits[CFG_LOGIC];
      end
      K_ADDC: begin rw = 1'b1; rv = sum9[7:0]; fw = 1'b1; fv = {7'd0, sum9[8]}; end
      K_SUB: begin rw = 1'b1; rv = vx - vy; fw = 1'b1; fv = {7'd0, vx >= vy}; end
      K_SUBN: begin rw = 1'b1; rv = vy - vx; fw = 1'b1; fv = {7'd0, vy >= vx}; end
      K_SHR: begin rw = 1'b1; rv = {1'b0, src[7:1]}; fw = 1'b1; fv = {7'd0, src[0]}; end
      K_SHL: begin rw = 1'b1; rv = {src[6:0], 1'b0}; fw = 1'b1; fv = {7'd0, src[7]}; end
      K_LDI: idx_new = {4'd0, it_r.imm};
      K_JPO: pc_new = 16'(jsrc) + {4'd0, it_r.imm};
      K_LDVD: begin rw = 1'b1; rv = dly_r; end
      K_ADDI: idx_new = idx_r + 16'(vx);
      K_FONT: idx_new = 16'(vx) * 16'd5;
      default: ;
    endcase
  end

  // Stack memory: registered read of the top entry.
  always_ff @(posedge clk) begin
    if (cmd.exec && run_r && it_r.kind == K_CALL && sp_r != DW'(STACK_DEPTH))
      stk[sp_r[SW-1:0]] <= pc2;
    stk_q <= stk[SW'(sp_r - DW'(1))];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      it_r <= item;
      vx_r <= v_r[item.x];
      base_r <= idx_r;
      run_at_r <= run_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) v_r[i] <= '0;
      pc_r <= PC_RESET; idx_r <= '0; sp_r <= '0;
      dly_r <= '0; snd_r <= '0; run_r <= 1'b1;
    end else if (cmd.exec && run_r) begin
      pc_r <= pc_new;
      idx_r <= idx_new;
      if (rw) v_r[it_r.x] <= rv;
      if (fw) v_r[15] <= fv;
      if (it_r.kind == K_EXIT) run_r <= 1'b0;
      if (it_r.kind == K_LDD) dly_r <= vx;
      if (it_r.kind == K_LDS) snd_r <= vx;
      if (it_r.kind == K_CALL && err == ERR_NONE) sp_r <= sp_r + DW'(1);
      if (it_r.kind == K_RET && err == ERR_NONE) sp_r <= sp_r - DW'(1);
    end else if (cmd.mem_step && cmd.k == '0) begin
      pc_r <= pc2;
      if (it_r.kind == K_STORE && cfg_bits[CFG_STORE])
        idx_r <= idx_r + 16'(it_r.x) + 16'd1;
    end
  end

  // Result word. For memory words, pc/index reflect the state after the
  // item; k=0 is formed before the update lands, so compute it directly.
  always_comb begin
    logic [15:0] idx_after;
    logic [7:0]  md;
    idx_after = (it_r.kind == K_STORE && cfg_bits[CFG_STORE])
              ? base_r + 16'(it_r.x) + 16'd1 : base_r;
    md = (it_r.kind == K_BCD) ? ((cmd.k == 4'd0) ? hund : (cmd.k == 4'd1) ? tens : rem)
       : v_r[cmd.k];
    res = '0;
    res.last = 1'b1;
    res.running = run_r;
    if (cmd.mem_step) begin
      res.pc = (cmd.k == '0) ? pc2 : pc_r;
      res.index = idx_after;
      res.flag_value = v_r[15];
      res.mem_write = 1'b1;
      res.mem_addr = base_r + 16'(cmd.k);
      res.mem_data = md;
      res.last = cmd.k_last;
    end else if (!run_r) begin
      res.pc = pc_r;
      res.index = idx_r;
      res.flag_value = v_r[15];
    end else begin
      res.pc = pc_new;
      res.index = idx_new;
      res.reg_written = rw;
      res.reg_number = rw ? it_r.x : 4'd0;
      res.reg_value = rv;
      res.flag_value = fw ? fv : ((rw && it_r.x == 4'd15) ? rv : v_r[15]);
      res.error = err;
      res.running = (it_r.kind == K_EXIT) ? 1'b0 : 1'b1;
    end
  end
endmodule
`default_nettype wire

/* sv/chip8_instruction_execute_unit.sv */
//------------------------------------------------------------------------------
// chip8_instruction_execute_unit
// Executes decoded CHIP-8 instructions and emits state and memory-write words.
//------------------------------------------------------------------------------
// Usage:
//   in   : one decoded instruction word (kind, x, y, imm), valid/ready.
//   out  : result words, valid/ready; one per instruction, or one per byte
//          written for BCD store (3) and block store (x+1), last on the final.
//   cfg  : APB-style port, registers at 4*i; four one-bit quirk settings.
// Timing: the sequencer accepts an item while idle, then executes it (the return
//   stack is read through a registered port whose output the execute state uses),
//   then hands words one per cycle into the output register while that register
//   is free. The sequencer handles one item at a time: it accepts no new item
//   until the last word of the current one is loaded into the output register.
// Reset: registers clear, PC loads 0x200, quirks return to defaults, the
//   block runs. The return stack holds no reset value.
// Stall: while the receiver holds ready low the output register holds its
//   word and the sequencer waits; no word is dropped.
//------------------------------------------------------------------------------
`default_nettype none
module chip8_instruction_execute_unit import c8x_pkg::*; #(
  parameter int STACK_DEPTH = 16
) (
  input  wire          clk,
  input  wire          rst_n,
  c8x_item_if.sink     in_ch,
  c8x_result_if.source out_ch,
  input  wire          cfg_psel,
  input  wire          cfg_penable,
  input  wire          cfg_pwrite,
  input  wire  [3:0]   cfg_paddr,
  input  wire  [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  logic [3:0] cfg_r, cfg_nxt;
  logic       ov_r;
  result_t    out_r, res;
  logic       res_load, res_ready, in_ready;
  cmd_t       cmd;
  stat_t      stat;
  item_t      item;

  // Config registers; quirk bits indexed by word address.
  assign cfg_pready = 1'b1;
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'd0)
      cfg_nxt[cfg_paddr[3:2]] = cfg_pwdata[0];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) cfg_r <= 4'b1011;
    else cfg_r <= cfg_nxt;
  end
  assign cfg_prdata = (cfg_paddr[1:0] == 2'd0) ? {31'd0, cfg_r[cfg_paddr[3:2]]} : '0;

  assign item = '{kind: in_ch.kind, x: in_ch.x, y: in_ch.y, imm: in_ch.imm};
  assign in_ch.ready = in_ready;

  // Output register: free when empty or draining this cycle.
  assign res_ready = !ov_r || out_ch.ready;
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (res_load) ov_r <= 1'b1;
    else if (out_ch.ready) ov_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (res_load) out_r <= res;
  end

  c8x_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ready),
    .res_ready(res_ready), .res_load(res_load), .cmd(cmd), .stat(stat)
  );

  c8x_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .load(in_ch.valid && in_ready), .item(item),
    .cmd(cmd), .stat(stat), .res(res), .cfg_bits(cfg_r)
  );

  assign out_ch.valid = ov_r;
  assign out_ch.pc = out_r.pc;
  assign out_ch.index = out_r.index;
  assign out_ch.reg_written = out_r.reg_written;
  assign out_ch.reg_number = out_r.reg_number;
  assign out_ch.reg_value = out_r.reg_value;
  assign out_ch.flag_value = out_r.flag_value;
  assign out_ch.mem_write = out_r.mem_write;
  assign out_ch.mem_addr = out_r.mem_addr;
  assign out_ch.mem_data = out_r.mem_data;
  assign out_ch.last = out_r.last;
  assign out_ch.error = out_r.error;
  assign out_ch.running = out_r.running;
endmodule
`default_nettype wire

/* sv/c8x_checker.sv */
//------------------------------------------------------------------------------
// c8x_checker
// Port-level checks of the execute unit.
//------------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module c8x_checker (
  input wire clk,
  input wire rst_n,
  input wire in_valid,
  input wire in_ready,
  input wire out_valid,
  input wire out_ready,
  input wire out_last,
  input wire out_mem_write,
  input wire out_reg_written,
  input wire [1:0] out_error,
  input wire out_running
);
  `ASSERT_NEXT(a_no_accept_busy, clk, rst_n, in_valid && in_ready, !in_ready)
  `ASSERT_IMPL(a_mem_no_reg, clk, rst_n, out_valid && out_mem_write, !out_reg_written)
  `ASSERT_IMPL(a_err_code, clk, rst_n, out_valid, out_error != 2'd3)
  `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `ASSERT_NEXT(a_stop, clk, rst_n, out_valid && out_ready && !out_running && out_last,
    !out_valid || !out_running)
endmodule
bind chip8_instruction_execute_unit c8x_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_last(out_ch.last),
  .out_mem_write(out_ch.mem_write), .out_reg_written(out_ch.reg_written),
  .out_error(out_ch.error), .out_running(out_ch.running)
);
`default_nettype wire

/* tb/tb_top.sv */
//------------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CHIP-8 execute unit.
// Drives decoded instructions under several quirk settings and idling phases.
// Predicts every result word from a private copy of the register file, PC,
// index, return stack and timers. Compares each word field by field, in order.
//------------------------------------------------------------------------------
`default_nettype none
module tb_top;
  import c8x_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STACK_LEVELS = 16;
  localparam int STALL_LIMIT  = 3000;

  // Executes each accepted instruction on a shadow machine and queues the
  // words the unit should emit for it.
  class exec_scoreboard;
    logic [7:0]  vreg [16];
    logic [15:0] pc_q, index_q;
    logic [15:0] calls [STACK_LEVELS];
    int          depth;
    logic [7:0]  delay_q, sound_q;
    bit          running_q;
    bit          q_logic, q_shift, q_jump, q_store;
    result_t     expected_words[$];
    bit          failed;

    function new();
      foreach (vreg[i]) vreg[i] = '0;
      pc_q = PC_RESET;
      index_q = '0;
      depth = 0;
      delay_q = '0;
      sound_q = '0;
      running_q = 1;
      q_logic = 1;
      q_shift = 1;
      q_jump = 0;
      q_store = 1;
      failed = 0;
    endfunction

    function void set_quirk(logic [1:0] sel, bit val);
      case (sel)
        CFG_LOGIC: q_logic = val;
        CFG_SHIFT: q_shift = val;
        CFG_JUMP:  q_jump = val;
        CFG_STORE: q_store = val;
        default: ;
      endcase
    endfunction

    function void push_word(bit rw, logic [3:0] rn, logic [7:0] rv, bit mw,
                            logic [15:0] ma, logic [7:0] md, bit lst, logic [1:0] err);
      result_t r;
      r.pc = pc_q;
      r.index = index_q;
      r.reg_written = rw;
      r.reg_number = rn;
      r.reg_value = rv;
      r.flag_value = vreg[15];
      r.mem_write = mw;
      r.mem_addr = ma;
      r.mem_data = md;
      r.last = lst;
      r.error = err;
      r.running = running_q;
      expected_words.push_back(r);
    endfunction

    function void note_item(item_t it);
      logic [7:0]  vx, vy, src, bval, rv, fv;
      logic [15:0] base;
      logic [1:0]  err;
      bit          rw, fw;
      if (!running_q) begin
        push_word(0, 0, 0, 0, 0, 0, 1, ERR_NONE);
        return;
      end
      pc_q = pc_q + 16'd2;
      vx = vreg[it.x];
      vy = vreg[it.y];
      bval = it.imm[7:0];
      rw = 0;
      fw = 0;
      rv = 0;
      fv = 0;
      err = ERR_NONE;
      case (it.kind)
        K_RET:
          if (depth == 0) err = ERR_UNDER;
          else begin
            depth--;
            pc_q = calls[depth];
          end
        K_EXIT: running_q = 0;
        K_JP: pc_q = {4'h0, it.imm};
        K_CALL:
          if (depth >= STACK_LEVELS) err = ERR_OVER;
          else begin
            calls[depth] = pc_q;
            depth++;
            pc_q = {4'h0, it.imm};
          end
        K_SEB:  if (vx == bval) pc_q = pc_q + 16'd2;
        K_SNEB: if (vx != bval) pc_q = pc_q + 16'd2;
        K_SER:  if (vx == vy) pc_q = pc_q + 16'd2;
        K_SNER: if (vx != vy) pc_q = pc_q + 16'd2;
        K_LDB:  begin rw = 1; rv = bval; end
        K_ADDB: begin rw = 1; rv = vx + bval; end
        K_LDR:  begin rw = 1; rv = vy; end
        K_OR, K_AND, K_XOR: begin
          rw = 1;
          rv = (it.kind == K_OR) ? (vx | vy) : (it.kind == K_AND) ? (vx & vy) : (vx ^ vy);
          fw = q_logic;
        end
        K_ADDC: begin rw = 1; fw = 1; {fv[0], rv} = {1'b0, vx} + {1'b0, vy}; end
        K_SUB:  begin rw = 1; fw = 1; rv = vx - vy; fv = {7'd0, vx >= vy}; end
        K_SUBN: begin rw = 1; fw = 1; rv = vy - vx; fv = {7'd0, vy >= vx}; end
        K_SHR: begin
          src = q_shift ? vy : vx;
          rw = 1; fw = 1; rv = src >> 1; fv = {7'd0, src[0]};
        end
        K_SHL: begin
          src = q_shift ? vy : vx;
          rw = 1; fw = 1; rv = src << 1; fv = {7'd0, src[7]};
        end
        K_LDI: index_q = {4'h0, it.imm};
        K_JPO: begin
          src = q_jump ? vreg[it.imm[11:8]] : vreg[0];
          pc_q = {8'h00, src} + {4'h0, it.imm};
        end
        K_LDVD: begin rw = 1; rv = delay_q; end
        K_LDD: delay_q = vx;
        K_LDS: sound_q = vx;
        K_ADDI: index_q = index_q + {8'h00, vx};
        K_FONT: index_q = {8'h00, vx} * 16'd5;
        K_BCD: begin
          base = index_q;
          push_word(0, 0, 0, 1, base, vx / 8'd100, 0, ERR_NONE);
          push_word(0, 0, 0, 1, base + 16'd1, (vx / 8'd10) % 8'd10, 0, ERR_NONE);
          push_word(0, 0, 0, 1, base + 16'd2, vx % 8'd10, 1, ERR_NONE);
          return;
        end
        K_STORE: begin
          base = index_q;
          if (q_store) index_q = base + {12'd0, it.x} + 16'd1;
          for (int k = 0; k <= it.x; k++)
            push_word(0, 0, 0, 1, base + k[15:0], vreg[k], k == it.x, ERR_NONE);
          return;
        end
        default: ;  // unknown codes only advance the PC
      endcase
      // V15 is written after Vx so the flag wins when x is fifteen
      if (rw) vreg[it.x] = rv;
      if (fw) vreg[15] = fv;
      push_word(rw, rw ? it.x : 4'd0, rw ? rv : 8'd0, 0, 0, 0, 1, err);
    endfunction

    function void compare_field(string fname, logic [15:0] exp_v, logic [15:0] got_v);
      if (exp_v !== got_v) begin
        failed = 1;
        $display("%0t: %s expected %0h actual %0h", $time, fname, exp_v, got_v);
      end
    endfunction

    function void check_word(result_t got);
      result_t e;
      if (expected_words.size() == 0) begin
        failed = 1;
        $display("%0t: unexpected word, expected none actual %h", $time, got);
        return;
      end
      e = expected_words.pop_front();
      compare_field("pc", e.pc, got.pc);
      compare_field("index", e.index, got.index);
      compare_field("reg_written", e.reg_written, got.reg_written);
      compare_field("reg_number", e.reg_number, got.reg_number);
      compare_field("reg_value", e.reg_value, got.reg_value);
      compare_field("flag_value", e.flag_value, got.flag_value);
      compare_field("mem_write", e.mem_write, got.mem_write);
      compare_field("mem_addr", e.mem_addr, got.mem_addr);
      compare_field("mem_data", e.mem_data, got.mem_data);
      compare_field("last", e.last, got.last);
      compare_field("error", e.error, got.error);
      compare_field("running", e.running, got.running);
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  c8x_item_if   in_if();
  c8x_result_if out_if();

  exec_scoreboard sb = new();
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  chip8_instruction_execute_unit DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    in_if.valid = 0;
    in_if.kind = '0;
    in_if.x = '0;
    in_if.y = '0;
    in_if.imm = '0;
    out_if.ready = 0;
  end

  // Throttle the result side; stall only in phases that ask for it.
  always @(posedge clk) begin
    out_if.ready <= (receiver_stall_pct == 0) || ($urandom_range(99) >= receiver_stall_pct);
  end

  // Capture every word that leaves the unit and score it.
  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.pc = out_if.pc;
      got.index = out_if.index;
      got.reg_written = out_if.reg_written;
      got.reg_number = out_if.reg_number;
      got.reg_value = out_if.reg_value;
      got.flag_value = out_if.flag_value;
      got.mem_write = out_if.mem_write;
      got.mem_addr = out_if.mem_addr;
      got.mem_data = out_if.mem_data;
      got.last = out_if.last;
      got.error = out_if.error;
      got.running = out_if.running;
      sb.check_word(got);
    end
  end

  // Watchdog: end the run if no word moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Write one quirk register: setup cycle, then access cycle.
  task automatic write_quirk(logic [1:0] sel, bit val);
    cfg_psel <= 1;
    cfg_penable <= 0;
    cfg_pwrite <= 1;
    cfg_paddr <= {sel, 2'b00};
    cfg_pwdata <= {31'd0, val};
    @(posedge clk);
    cfg_penable <= 1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_quirk(sel, val);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
  endtask

  task automatic set_quirks(bit lg, bit sh, bit jp, bit st);
    write_quirk(CFG_LOGIC, lg);
    write_quirk(CFG_SHIFT, sh);
    write_quirk(CFG_JUMP, jp);
    write_quirk(CFG_STORE, st);
  endtask

  // Offer one word, idling first at the phase's rate; hold until accepted.
  task automatic send(logic [4:0] kind, logic [3:0] x, logic [3:0] y, logic [11:0] imm);
    item_t it;
    if (sender_idle_pct != 0) begin
      while ($urandom_range(99) < sender_idle_pct) begin
        in_if.valid <= 0;
        @(posedge clk);
      end
    end
    in_if.valid <= 1;
    in_if.kind <= kind;
    in_if.x <= x;
    in_if.y <= y;
    in_if.imm <= imm;
    do @(posedge clk); while (!in_if.ready);
    it.kind = kind;
    it.x = x;
    it.y = y;
    it.imm = imm;
    sb.note_item(it);
  endtask

  // Drop valid and let all expected words drain, plus a short settle.
  task automatic drain();
    in_if.valid <= 0;
    @(posedge clk);
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Random instruction; exit is kept for the very end of the run.
  task automatic send_random();
    logic [4:0] kind;
    kind = 5'($urandom_range(31));
    if (kind == K_EXIT) kind = K_LDB;
    send(kind, 4'($urandom_range(15)), 4'($urandom_range(15)),
         12'($urandom_range(4095)));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: extremes, flag order with x fifteen, wraps, every operation but exit.
    send(K_RET, 0, 0, 0);                 // underflow on empty stack
    send(K_LDB, 0, 0, 12'h0FF);
    send(K_LDB, 1, 0, 12'h001);
    send(K_ADDC, 0, 1, 0);                // carry out
    send(K_SUB, 1, 0, 0);                 // no borrow, flag set
    send(K_SUBN, 2, 0, 0);
    send(K_LDB, 15, 0, 12'h081);
    send(K_SHL, 15, 15, 0);               // flag overrides result in V15
    send(K_SHR, 3, 0, 0);
    send(K_ADDC, 15, 0, 0);
    send(K_OR, 4, 0, 0);
    send(K_AND, 5, 0, 0);
    send(K_XOR, 6, 0, 0);
    send(K_SEB, 0, 0, 12'hFFF);
    send(K_SNEB, 0, 0, 12'h000);
    send(K_SER, 0, 0, 0);
    send(K_SNER, 0, 1, 0);
    send(K_ADDB, 0, 0, 12'h0FF);
    send(K_LDR, 7, 0, 0);
    send(K_LDD, 0, 0, 0);
    send(K_LDS, 0, 0, 0);
    send(K_LDVD, 8, 0, 0);
    send(K_LDI, 0, 0, 12'hFFE);
    send(K_BCD, 0, 0, 0);                 // addresses 0xFFE..0x1000
    send(K_ADDI, 0, 0, 0);
    send(K_FONT, 0, 0, 0);
    send(K_STORE, 15, 0, 0);
    send(K_JPO, 0, 0, 12'hF00);
    send(K_JP, 0, 0, 12'hFFF);
    send(5'd31, 0, 0, 0);                 // unknown code
    // Fill the stack, overflow once, then unwind it past empty.
    for (int i = 0; i <= STACK_LEVELS; i++) send(K_CALL, 0, 0, 12'($urandom_range(4095)));
    for (int i = 0; i <= STACK_LEVELS; i++) send(K_RET, 0, 0, 0);
    drain();

    // Random phases, each with its own quirk setting and idling pattern.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_quirks(0, 0, 0, 0);
        1: set_quirks(1, 1, 1, 1);
        2: set_quirks(1, 0, 1, 0);
        default: set_quirks(0, 1, 0, 1);
      endcase
      sender_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 31 : 54) : 0;
      receiver_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 31 : 54) : 0;
      for (int n = 0; n < 26; n++) send_random();
      drain();
    end

    // Halt the machine; later words must report unchanged state.
    send(K_EXIT, 0, 0, 0);
    send(K_LDB, 3, 0, 12'h0AA);
    send(K_STORE, 15, 0, 0);
    drain();
    repeat (20) @(posedge clk);

    if (!sb.failed && sb.expected_words.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+sv
sv/c8x_pkg.sv
sv/c8x_if.sv
sv/c8x_ctrl.sv
sv/c8x_dp.sv
sv/chip8_instruction_execute_unit.sv
sv/c8x_checker.sv
tb/tb_top.sv
